@@ rtl/core/u2h_pkg.sv @@
// Package for the UTF-8 to UCS-2 hex text converter.
// Holds shared widths, byte class limits, the queue entry type and the hex digit function.
`timescale 1ns / 1ps

package u2h_pkg;

  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CodeWidth  = 11;
  localparam int unsigned HexWidth   = 7;
  localparam int unsigned QueueDepth = 4;

  localparam logic [ByteWidth-1:0] AsciiMax = 8'h7F;
  localparam logic [ByteWidth-1:0] PairMax  = 8'hDF;
  localparam logic [ByteWidth-1:0] Drop2Max = 8'hEF;
  localparam logic [ByteWidth-1:0] Drop3Max = 8'hF4;

  localparam logic [1:0] DropTwo   = 2'd2;
  localparam logic [1:0] DropThree = 2'd3;
  localparam logic [1:0] LastDigit = 2'd3;

  localparam logic [HexWidth-1:0] CharZero = 7'h30;
  localparam logic [HexWidth-1:0] CharNine = 7'h39;
  localparam logic [HexWidth-1:0] CharA    = 7'h41;
  localparam logic [HexWidth-1:0] CharF    = 7'h46;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_PAIR = 3'b010,
    MODE_DROP = 3'b100
  } mode_e;

  // One decoded code unit on its way from the front end to the queue.
  typedef struct packed {
    logic                 push;
    logic [CodeWidth-1:0] code;
  } code_req_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic                 avail;
    logic [CodeWidth-1:0] code;
  } code_head_t;

  // ASCII upper-case hex digit of one nibble of the code zero-extended to 16 bits, MSB nibble first.
  function automatic logic [HexWidth-1:0] hex_digit(logic [CodeWidth-1:0] code,
                                                    logic [1:0] idx);
    logic [15:0] full;
    logic [3:0]  nib;
    full = {{(16 - CodeWidth){1'b0}}, code};
    case (idx)
      2'd0:    nib = full[15:12];
      2'd1:    nib = full[11:8];
      2'd2:    nib = full[7:4];
      default: nib = full[3:0];
    endcase
    if (nib < 4'd10) begin
      hex_digit = CharZero + {3'b000, nib};
    end else begin
      hex_digit = CharA + {3'b000, nib - 4'd10};
    end
  endfunction

endpackage

@@ rtl/core/u2h_byte_if.sv @@
// Byte input channel of the converter: valid/ready handshake with byte and end flag.
// Depends on u2h_pkg for the byte width.
`timescale 1ns / 1ps

interface u2h_byte_if;
  import u2h_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] in_byte;
  logic                 string_end;

  modport source (output valid, in_byte, string_end, input ready);
  modport sink (input valid, in_byte, string_end, output ready);
endinterface

@@ rtl/core/u2h_hex_if.sv @@
// Hex character output channel of the converter: valid/ready handshake with digit and flag.
// Depends on u2h_pkg for the character width.
`timescale 1ns / 1ps

interface u2h_hex_if;
  import u2h_pkg::*;

  logic                valid;
  logic                ready;
  logic [HexWidth-1:0] hex_char;
  logic                run_last;

  modport source (output valid, hex_char, run_last, input ready);
  modport sink (input valid, hex_char, run_last, output ready);
endinterface

@@ rtl/core/u2h_front.sv @@
// Front end: takes UTF-8 bytes, tracks the decode mode and emits 11-bit code units.
// Depends on u2h_pkg.
`timescale 1ns / 1ps

module u2h_front import u2h_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [ByteWidth-1:0] in_byte_i,
  input  logic                 string_end_i,
  output code_req_t            req_o
);

  mode_e      mode_q, mode_d;
  logic [4:0] pend_q, pend_d;
  logic [1:0] drop_q, drop_d;
  code_req_t  req;

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    drop_d   = drop_q;
    req.push = 1'b0;
    req.code = '0;
    if (accept_i) begin
      unique case (mode_q)
        MODE_PAIR: begin
          req.push = 1'b1;
          req.code = {pend_q, in_byte_i[5:0]};
          mode_d   = MODE_IDLE;
          pend_d   = '0;
          drop_d   = '0;
        end
        MODE_DROP: begin
          drop_d = drop_q - 2'd1;
          if (drop_d == 2'd0) begin
            mode_d = MODE_IDLE;
            pend_d = '0;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          pend_d = '0;
          drop_d = '0;
          if (in_byte_i <= AsciiMax) begin
            req.push = 1'b1;
            req.code = {{(CodeWidth - 7){1'b0}}, in_byte_i[6:0]};
          end else if (in_byte_i <= PairMax) begin
            if (string_end_i) begin
              req.push = 1'b1;
              req.code = {in_byte_i[4:0], 6'b000000};
            end else begin
              pend_d = in_byte_i[4:0];
              mode_d = MODE_PAIR;
            end
          end else if (in_byte_i <= Drop2Max) begin
            drop_d = DropTwo;
            mode_d = MODE_DROP;
          end else if (in_byte_i <= Drop3Max) begin
            drop_d = DropThree;
            mode_d = MODE_DROP;
          end
        end
      endcase
      if (string_end_i) begin
        mode_d = MODE_IDLE;
        pend_d = '0;
        drop_d = '0;
      end
    end
  end

  assign req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= '0;
      drop_q <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      drop_q <= drop_d;
    end
  end

endmodule

@@ rtl/core/u2h_queue.sv @@
// Short code unit queue between the front and back ends.
// Depends on u2h_pkg for the entry width and the request and head types.
`timescale 1ns / 1ps

module u2h_queue import u2h_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  code_req_t  req_i,
  input  logic       pop_i,
  output logic       full_o,
  output code_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CodeWidth-1:0] mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = req_i.push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(req_i.push) - CntW'(pop_i);
  end

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.avail = (count_q != '0);
  assign head_o.code  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_ptr_q] <= req_i.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/core/u2h_back.sv @@
// Back end: serializes each code unit into four hex digits through an output register.
// Depends on u2h_pkg.
`timescale 1ns / 1ps

module u2h_back import u2h_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  code_head_t          head_i,
  output logic                pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [HexWidth-1:0] hex_char_o,
  output logic                run_last_o
);

  logic [CodeWidth-1:0] code_q, code_d;
  logic [1:0]           idx_q, idx_d;
  logic                 have_q, have_d;
  logic                 valid_q, valid_d;
  logic [HexWidth-1:0]  char_q, char_d;
  logic                 last_q, last_d;
  logic                 slot_free;

  assign slot_free = !valid_q || out_ready_i;

  always_comb begin
    code_d  = code_q;
    idx_d   = idx_q;
    have_d  = have_q;
    valid_d = valid_q && !out_ready_i;
    char_d  = char_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (slot_free) begin
      if (have_q) begin
        valid_d = 1'b1;
        char_d  = hex_digit(code_q, idx_q);
        last_d  = (idx_q == LastDigit);
        idx_d   = idx_q + 2'd1;
        have_d  = (idx_q != LastDigit);
      end else if (head_i.avail) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        char_d  = hex_digit(head_i.code, 2'd0);
        last_d  = 1'b0;
        code_d  = head_i.code;
        idx_d   = 2'd1;
        have_d  = 1'b1;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign hex_char_o  = char_q;
  assign run_last_o  = last_q;

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      have_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      have_q  <= have_d;
      valid_q <= valid_d;
    end
  end

endmodule

@@ rtl/core/utf8_to_ucs2_hex_text.sv @@
// Top level of the UTF-8 to UCS-2 hex text converter: front end, queue and back end.
// Depends on u2h_pkg, u2h_byte_if, u2h_hex_if, u2h_front, u2h_queue and u2h_back.
//
//   Channel | Direction | Word contents
//   --------+-----------+----------------------------------------------------
//   in_i    | sink      | in_byte (8 bits), string_end (1 bit)
//   out_o   | source    | hex_char (7 bits ASCII), run_last (1 bit, 4th digit)
//
// A byte is taken in the cycle it is offered as long as the code queue has room.
// Each one- or two-byte character gives four digits, one per cycle while out_o is ready,
// so a stream of such characters is paced by the single-digit output port.
// Bytes that give no digits push nothing into the queue. Reset clears the decode state, the
// queue and the output register; there is no clearing pass.
// A stalled output fills the queue and then drops in_i.ready; the front end keeps
// decoding into the queue while the back end waits.
`timescale 1ns / 1ps

module utf8_to_ucs2_hex_text import u2h_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2h_byte_if.sink   in_i,
  u2h_hex_if.source  out_o
);

  code_req_t  req;
  code_head_t head;
  logic       queue_full;
  logic       pop;
  logic       accept;

  // The queue must have space for a possible code unit before a byte is taken.
  assign in_i.ready = !queue_full;
  assign accept     = in_i.valid && !queue_full;

  u2h_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_i.in_byte),
    .string_end_i (in_i.string_end),
    .req_o        (req)
  );

  u2h_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pop_i  (pop),
    .full_o (queue_full),
    .head_o (head)
  );

  // The back end pulls one code unit and then emits its digits back to back.
  u2h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .hex_char_o  (out_o.hex_char),
    .run_last_o  (out_o.run_last)
  );

endmodule

@@ rtl/core/u2h_checker.sv @@
// Port-level checker for the converter and its bind to the top level.
// Depends on u2h_pkg and utf8_to_ucs2_hex_text.
`timescale 1ns / 1ps

module u2h_checker import u2h_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [HexWidth-1:0] hex_char_i,
  input logic                run_last_i
);

  // Nothing is offered while reset is held.
  a_idle_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // Every digit is an upper-case hex character.
  a_hex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((hex_char_i >= CharZero && hex_char_i <= CharNine) ||
                     (hex_char_i >= CharA && hex_char_i <= CharF)))
    else $error("output is not a hex digit");

  // The digits of one code unit follow each other without a gap.
  a_digits_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !run_last_i |=> out_valid_i)
    else $error("gap inside a code unit");

  // A stalled word holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(hex_char_i) && $stable(run_last_i))
    else $error("output changed while stalled");

endmodule

bind utf8_to_ucs2_hex_text u2h_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .hex_char_i  (out_o.hex_char),
  .run_last_i  (out_o.run_last)
);
